### hw/rtl/pdeque_pkg.sv
// Shared types and constants for the positional deque.
// Holds the request and response transaction structs, the action and
// status codes and the control bundle that drives the cell chain.
package pdeque_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Action codes carried in the request.
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
	localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
	localparam logic [2:0] ACT_POP_BACK   = 3'd2;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [2:0] ACT_INSERT     = 3'd4;
	localparam logic [2:0] ACT_DELETE     = 3'd5;

	// Status codes carried in the response.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef logic signed [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [4:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [4:0]         length;
		logic               is_empty;
	} rsp_t;

	// Shift command broadcast to every cell.
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] idx;
		word_t            word;
	} cell_ctl_t;

	// Decoded request from the control unit.
	typedef struct packed {
		cell_ctl_t        ctl;
		logic [1:0]       status;
		logic [CNT_W-1:0] count_nxt;
	} pd_dec_t;

endpackage

### hw/rtl/pdeque_cell.sv
// One storage cell of the deque chain.
// Depends on pdeque_pkg for the word type and the shift command bundle.
module pdeque_cell (
	input  logic                        clk,
	input  logic [pdeque_pkg::IDX_W-1:0] cell_id,
	input  pdeque_pkg::cell_ctl_t       ctl,
	input  pdeque_pkg::word_t           left_word,
	input  pdeque_pkg::word_t           right_word,
	output pdeque_pkg::word_t           word_q
);
	import pdeque_pkg::*;

	word_t word_nxt;

	// An insert takes the new word at the target cell and shifts cells behind it
	// one place toward the back; a delete pulls cells at or behind the target forward.
	always_comb begin
		word_nxt = word_q;
		if (ctl.ins) begin
			if (cell_id == ctl.idx) begin
				word_nxt = ctl.word;
			end else if (cell_id > ctl.idx) begin
				word_nxt = left_word;
			end
		end else if (ctl.del) begin
			if (cell_id >= ctl.idx) begin
				word_nxt = right_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

endmodule

### hw/rtl/pdeque_ctrl.sv
// Request decoder for the positional deque.
// Checks a request against the current count and issues the cell shift command.
// Depends on pdeque_pkg.
module pdeque_ctrl (
	input  pdeque_pkg::req_t                   req,
	input  logic [pdeque_pkg::CNT_W-1:0]       count_q,
	output pdeque_pkg::pd_dec_t                dec
);
	import pdeque_pkg::*;

	logic             full;
	logic             empty;
	logic             pos_ok;
	logic [4:0]       pos_m1;
	logic [CNT_W-1:0] last;

	assign full   = 32'(count_q) >= 32'(CAPACITY);
	assign empty  = count_q == '0;
	assign pos_ok = (req.position != 5'd0) && (32'(req.position) <= 32'(count_q));
	assign pos_m1 = req.position - 5'd1;
	assign last   = count_q - CNT_W'(1);

	// Decide the outcome and the shift for each action.
	always_comb begin
		dec           = '0;
		dec.ctl.word  = DATA_WIDTH'(req.value);
		dec.status    = ST_OK;
		dec.count_nxt = count_q;
		unique case (req.action)
			ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
				if (full) begin
					dec.status = ST_FULL;
				end else begin
					dec.ctl.ins   = 1'b1;
					dec.ctl.idx   = (req.action == ACT_PUSH_BACK) ? count_q[IDX_W-1:0] : '0;
					dec.count_nxt = count_q + CNT_W'(1);
				end
			end
			ACT_POP_BACK, ACT_POP_FRONT: begin
				if (empty) begin
					dec.status = ST_EMPTY;
				end else begin
					dec.ctl.del   = 1'b1;
					dec.ctl.idx   = (req.action == ACT_POP_BACK) ? last[IDX_W-1:0] : '0;
					dec.count_nxt = last;
				end
			end
			ACT_INSERT: begin
				if (!pos_ok) begin
					dec.status = ST_RANGE;
				end else if (full) begin
					dec.status = ST_FULL;
				end else begin
					dec.ctl.ins   = 1'b1;
					dec.ctl.idx   = pos_m1[IDX_W-1:0];
					dec.count_nxt = count_q + CNT_W'(1);
				end
			end
			ACT_DELETE: begin
				if (!pos_ok) begin
					dec.status = ST_RANGE;
				end else begin
					dec.ctl.del   = 1'b1;
					dec.ctl.idx   = pos_m1[IDX_W-1:0];
					dec.count_nxt = last;
				end
			end
			default: begin
				dec.status = ST_OK;
			end
		endcase
	end

endmodule

### hw/rtl/positional_deque_top.sv
// Top level of the positional deque: decoder, cell chain and response register.
// Depends on pdeque_pkg, pdeque_ctrl and pdeque_cell.
//
// The deque keeps up to CAPACITY signed words in a chain of cells, cell 0
// being the front. Every request transaction gives exactly one response
// transaction, registered on acceptance. All cells decide their shift in the
// same cycle from a compare of their own index with the target index, so a
// new request is taken every cycle; the only limit is the single response
// register, which holds the request side off while its response is stalled.
// No clearing pass follows reset; only the count and the response valid flag reset.
module positional_deque_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  pdeque_pkg::req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output pdeque_pkg::rsp_t rsp
);
	import pdeque_pkg::*;

	logic             accept;
	logic [CNT_W-1:0] count_q;
	pd_dec_t          dec;
	cell_ctl_t        ctl;
	word_t            words [CAPACITY];
	word_t            rd_word;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;

	pdeque_ctrl u_ctrl (
		.req     (req),
		.count_q (count_q),
		.dec     (dec)
	);

	// Shift command only takes effect on an accepted transaction.
	always_comb begin
		ctl     = dec.ctl;
		ctl.ins = dec.ctl.ins & accept;
		ctl.del = dec.ctl.del & accept;
	end

	// Chain of cells, each linked to its neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t left_word;
		word_t right_word;
		if (i == 0) begin : g_first
			assign left_word = '0;
		end else begin : g_left
			assign left_word = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_word = '0;
		end else begin : g_right
			assign right_word = words[i+1];
		end
		pdeque_cell u_cell (
			.clk        (clk),
			.cell_id    (IDX_W'(i)),
			.ctl        (ctl),
			.left_word  (left_word),
			.right_word (right_word),
			.word_q     (words[i])
		);
	end

	// Word leaving the chain on a pop or delete.
	assign rd_word = words[dec.ctl.idx];

	// Word count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= dec.count_nxt;
		end
	end

	// Response register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status        <= dec.status;
			rsp_q.removed_value <= dec.ctl.del ? 32'(rd_word) : 32'sd0;
			rsp_q.length        <= 5'(dec.count_nxt);
			rsp_q.is_empty      <= dec.count_nxt == '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for positional_deque_top.
// Depends on pdeque_pkg and the positional_deque_top RTL; holds a shadow
// deque that predicts every response and checks it as it arrives.
module tb;
	import pdeque_pkg::*;

	// Action codes the block decodes as no operation.
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_ITEMS   = 100;

	// Shadow copy of the deque: predicts the response of each accepted request
	// and compares arriving responses with the oldest prediction.
	class deque_tracker;
		word_t cells[CAPACITY];
		int    count;
		rsp_t  due_rsps[$];
		int    errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function void put(int idx, word_t w);
			for (int i = count; i > idx; i--)
				cells[i] = cells[i-1];
			cells[idx] = w;
			count++;
		endfunction

		function word_t take(int idx);
			word_t w;
			w = cells[idx];
			for (int i = idx; i < count - 1; i++)
				cells[i] = cells[i+1];
			count--;
			return w;
		endfunction

		function int pending();
			return due_rsps.size();
		endfunction

		// Applies one accepted request to the shadow deque and queues its response.
		function void note_request(req_t r);
			rsp_t want;
			int   pos;
			want        = '0;
			want.status = ST_OK;
			pos         = int'(r.position);
			case (r.action)
				ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
					if (count >= CAPACITY)
						want.status = ST_FULL;
					else
						put((r.action == ACT_PUSH_BACK) ? count : 0, word_t'(r.value));
				end
				ACT_POP_BACK, ACT_POP_FRONT: begin
					if (count == 0)
						want.status = ST_EMPTY;
					else
						want.removed_value = take((r.action == ACT_POP_BACK) ? count - 1 : 0);
				end
				ACT_INSERT: begin
					// The position is checked before fullness.
					if (pos < 1 || pos > count)
						want.status = ST_RANGE;
					else if (count >= CAPACITY)
						want.status = ST_FULL;
					else
						put(pos - 1, word_t'(r.value));
				end
				ACT_DELETE: begin
					if (pos < 1 || pos > count)
						want.status = ST_RANGE;
					else
						want.removed_value = take(pos - 1);
				end
				default: begin
				end
			endcase
			want.length   = 5'(count);
			want.is_empty = (count == 0);
			due_rsps.push_back(want);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				if (errors < 50)
					$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Checks one accepted response against the oldest prediction.
		function void check_response(rsp_t got);
			rsp_t want;
			if (due_rsps.size() == 0) begin
				if (errors < 50)
					$display("%0t: response with none expected: expected nothing, actual %h",
						$time, got);
				errors++;
				return;
			end
			want = due_rsps.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("removed_value", want.removed_value, got.removed_value);
			compare_field("length", 32'(want.length), 32'(got.length));
			compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	deque_tracker shadow;
	bit           tx_idling;

	positional_deque_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#5000000;
		$display("positional_deque_top test failed");
		$finish;
	end

	// Idle length in cycles: mostly short, now and then long.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return $urandom_range(1, 2);
		else if (roll < 90)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t make_req(logic [2:0] act, logic [4:0] pos, logic [31:0] val);
		req_t r;
		r.action   = act;
		r.position = pos;
		r.value    = val;
		return r;
	endfunction

	// Offers one request transaction and holds it until it is accepted.
	task automatic send(input req_t item);
		int gap;
		gap = 0;
		if (tx_idling && $urandom_range(0, 2) == 0)
			gap = idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		shadow.note_request(item);
	endtask

	// Random request biased toward growing the deque by grow_pct percent.
	function automatic req_t random_req(int grow_pct);
		req_t r;
		int   roll;
		int   len;
		len = shadow.count;
		case ($urandom_range(0, 9))
			0:       r.value = 32'h7fffffff;
			1:       r.value = 32'h80000000;
			2:       r.value = 32'hffffffff;
			default: r.value = $urandom();
		endcase
		r.position = 5'($urandom_range(0, 31));
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			r.action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
			return r;
		end
		roll = $urandom_range(0, 99);
		if (roll < grow_pct) begin
			case ($urandom_range(0, 2))
				0:       r.action = ACT_PUSH_BACK;
				1:       r.action = ACT_PUSH_FRONT;
				default: r.action = ACT_INSERT;
			endcase
		end else begin
			case ($urandom_range(0, 2))
				0:       r.action = ACT_POP_BACK;
				1:       r.action = ACT_POP_FRONT;
				default: r.action = ACT_DELETE;
			endcase
		end
		// Insert and delete mostly name a real element; the rest are out of range.
		if (r.action == ACT_INSERT || r.action == ACT_DELETE) begin
			if ($urandom_range(0, 99) < 85)
				r.position = 5'($urandom_range(1, (len == 0) ? 1 : len));
			else if ($urandom_range(0, 1) == 0 || len >= 31)
				r.position = 5'd0;
			else
				r.position = 5'($urandom_range(len + 1, 31));
		end
		return r;
	endfunction

	// Extremes of the fields and every error case, from empty up to full, then removals.
	task automatic directed_reqs();
		send(make_req(ACT_POP_BACK, 5'd0, 32'd0));
		send(make_req(ACT_POP_FRONT, 5'd31, 32'd0));
		send(make_req(ACT_DELETE, 5'd1, 32'd0));
		send(make_req(ACT_INSERT, 5'd1, 32'd5));
		send(make_req(ACT_SPARE_6, 5'd3, 32'h12345678));
		send(make_req(ACT_SPARE_7, 5'd31, 32'hffffffff));
		send(make_req(ACT_PUSH_BACK, 5'd0, 32'h7fffffff));
		send(make_req(ACT_PUSH_FRONT, 5'd0, 32'h80000000));
		send(make_req(ACT_INSERT, 5'd2, 32'hffffffff));
		send(make_req(ACT_INSERT, 5'd0, 32'd7));
		send(make_req(ACT_INSERT, 5'd31, 32'd7));
		send(make_req(ACT_DELETE, 5'd3, 32'd0));
		send(make_req(ACT_DELETE, 5'd0, 32'd0));
		send(make_req(ACT_DELETE, 5'd3, 32'd0));
		for (int k = 0; k < CAPACITY - 2; k++)
			send(make_req(ACT_PUSH_BACK, 5'(k), $urandom()));
		send(make_req(ACT_PUSH_BACK, 5'd0, 32'd1));
		send(make_req(ACT_PUSH_FRONT, 5'd0, 32'd2));
		send(make_req(ACT_INSERT, 5'd16, 32'd3));
		send(make_req(ACT_INSERT, 5'd17, 32'd4));
		send(make_req(ACT_DELETE, 5'd16, 32'd0));
		send(make_req(ACT_POP_FRONT, 5'd0, 32'd0));
		send(make_req(ACT_POP_BACK, 5'd0, 32'd0));
	endtask

	// Request side: reset, directed requests, then phases of random requests.
	initial begin
		int grow;
		shadow    = new();
		tx_idling = 1'b1;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_reqs();
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			tx_idling = (ph % 3 != 1);
			case (ph % 4)
				0:       grow = 80;
				1:       grow = 50;
				2:       grow = 20;
				default: grow = 60;
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send(random_req(grow));
		end
		req_valid <= 1'b0;
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (shadow.errors == 0)
			$display("positional_deque_top test passed");
		else
			$display("positional_deque_top test failed");
		$finish;
	end

	// Response side: checks each accepted response and drives the stall.
	initial begin
		int stall_left;
		int hold_at;
		int mode_left;
		int seen;
		bit busy;
		stall_left = 0;
		hold_at    = 450;
		mode_left  = 100;
		seen       = 0;
		busy       = 1'b1;
		rsp_stall  <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				shadow.check_response(rsp);
				seen++;
			end
			// Alternate between stretches with and without random stalls.
			if (mode_left == 0) begin
				busy      = ($urandom_range(0, 2) != 0);
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if (seen >= hold_at) begin
				// Long hold-off so the block backs up and stalls its requests.
				hold_at   += 550;
				stall_left = 299;
				rsp_stall <= 1'b1;
			end else if (busy && $urandom_range(0, 3) == 0) begin
				stall_left = idle_len() - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

endmodule
